FILE: hw/rtl/nearest_color_center_core_assert.svh
// Assertion helpers for the top-level core; expects clk and rst in scope.
`ifndef NEAREST_COLOR_CENTER_CORE_ASSERT_SVH
`define NEAREST_COLOR_CENTER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/ncc_pkg.sv
`timescale 1ns / 1ps
package ncc_pkg;

  localparam int CHAN_W          = 8;
  localparam int CENTER_W        = 24;
  localparam int SUM_W           = 18;
  localparam int ROOT_W          = 9;
  localparam int IDX_W           = 3;
  localparam int CNT_W           = 3;
  localparam int CFG_INDEX_W     = 3;
  localparam int LANES           = 8;
  localparam int MAX_CENTERS_DEF = 7;

  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_COUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_BASE  = 3'd1;

  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [ROOT_W-1:0] root_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam sum_t SUM_NONE = {SUM_W{1'b1}};

endpackage

FILE: hw/rtl/ncc_dist.sv
`timescale 1ns / 1ps
module ncc_dist #(
  parameter int MAX_CENTERS = ncc_pkg::MAX_CENTERS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            in_valid,
  output logic                                            in_ready,
  input  logic [2:0][ncc_pkg::CHAN_W-1:0]                 pixel,
  input  logic [MAX_CENTERS-1:0][ncc_pkg::CENTER_W-1:0]   centers,
  input  logic [ncc_pkg::CNT_W-1:0]                       count_eff,
  output logic                                            out_valid,
  input  logic                                            out_ready,
  output logic [MAX_CENTERS-1:0][ncc_pkg::SUM_W-1:0]      sums
);
  import ncc_pkg::*;

  localparam int SQ_W = 2 * CHAN_W;

  logic [2:0] vld;
  logic [2:0] en;

  logic [MAX_CENTERS-1:0][2:0][CHAN_W-1:0] diff_q;
  logic [MAX_CENTERS-1:0][2:0][SQ_W-1:0]   sq_q;
  logic [MAX_CENTERS-1:0][SUM_W-1:0]       sum_q;

  always_comb begin
    en[2] = !vld[2] || out_ready;
    en[1] = !vld[1] || en[2];
    en[0] = !vld[0] || en[1];
  end

  assign in_ready  = en[0];
  assign out_valid = vld[2];
  assign sums      = sum_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_CENTERS; i++) begin
      for (int c = 0; c < 3; c++) begin
        if (en[0]) begin
          if (pixel[c] >= centers[i][c*CHAN_W +: CHAN_W]) begin
            diff_q[i][c] <= pixel[c] - centers[i][c*CHAN_W +: CHAN_W];
          end else begin
            diff_q[i][c] <= centers[i][c*CHAN_W +: CHAN_W] - pixel[c];
          end
        end
        if (en[1]) sq_q[i][c] <= SQ_W'(diff_q[i][c]) * SQ_W'(diff_q[i][c]);
      end
      if (en[2]) begin
        if (CNT_W'(i) < count_eff) begin
          sum_q[i] <= SUM_W'(sq_q[i][0]) + SUM_W'(sq_q[i][1]) + SUM_W'(sq_q[i][2]);
        end else begin
          sum_q[i] <= SUM_NONE;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/ncc_min.sv
`timescale 1ns / 1ps
module ncc_min #(
  parameter int MAX_CENTERS = ncc_pkg::MAX_CENTERS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [MAX_CENTERS-1:0][ncc_pkg::SUM_W-1:0]  in_sums,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [ncc_pkg::SUM_W-1:0]                   min_sum,
  output logic [MAX_CENTERS-1:0][ncc_pkg::SUM_W-1:0]  out_sums
);
  import ncc_pkg::*;

  logic [1:0] vld;
  logic [1:0] en;

  sum_t                              lane [LANES];
  sum_t                              m4   [LANES/2];
  sum_t                              m2   [LANES/4];
  sum_t                              pair_q [LANES/4];
  logic [MAX_CENTERS-1:0][SUM_W-1:0] sums_a_q;
  logic [MAX_CENTERS-1:0][SUM_W-1:0] sums_b_q;
  sum_t                              min_q;

  always_comb begin
    en[1] = !vld[1] || out_ready;
    en[0] = !vld[0] || en[1];
  end

  assign in_ready  = en[0];
  assign out_valid = vld[1];
  assign min_sum   = min_q;
  assign out_sums  = sums_b_q;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lane[i] = SUM_NONE;
    end
    for (int i = 0; i < MAX_CENTERS; i++) begin
      lane[i] = in_sums[i];
    end
    for (int j = 0; j < LANES/2; j++) begin
      m4[j] = (lane[2*j+1] < lane[2*j]) ? lane[2*j+1] : lane[2*j];
    end
    for (int k = 0; k < LANES/4; k++) begin
      m2[k] = (m4[2*k+1] < m4[2*k]) ? m4[2*k+1] : m4[2*k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < LANES/4; k++) pair_q[k] <= m2[k];
      sums_a_q <= in_sums;
    end
    if (en[1]) begin
      min_q    <= (pair_q[1] < pair_q[0]) ? pair_q[1] : pair_q[0];
      sums_b_q <= sums_a_q;
    end
  end

endmodule

FILE: hw/rtl/ncc_sqrt.sv
`timescale 1ns / 1ps
module ncc_sqrt #(
  parameter int MAX_CENTERS = ncc_pkg::MAX_CENTERS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [ncc_pkg::SUM_W-1:0]                   in_val,
  input  logic [MAX_CENTERS-1:0][ncc_pkg::SUM_W-1:0]  in_sums,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [ncc_pkg::ROOT_W-1:0]                  root,
  output logic [MAX_CENTERS-1:0][ncc_pkg::SUM_W-1:0]  out_sums
);
  import ncc_pkg::*;

  logic [ROOT_W-1:0] vld;
  logic [ROOT_W-1:0] en;

  root_t                             root_q [ROOT_W];
  sum_t                              val_q  [ROOT_W];
  logic [MAX_CENTERS-1:0][SUM_W-1:0] sums_q [ROOT_W];

  always_comb begin
    en[ROOT_W-1] = !vld[ROOT_W-1] || out_ready;
    for (int k = ROOT_W-2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[ROOT_W-1];
  assign root      = root_q[ROOT_W-1];
  assign out_sums  = sums_q[ROOT_W-1];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic                              vin;
    root_t                             root_in;
    sum_t                              val_in;
    logic [MAX_CENTERS-1:0][SUM_W-1:0] sums_in;
    root_t                             trial;
    sum_t                              trial_sq;

    if (k == 0) begin : g_first
      assign vin     = in_valid;
      assign root_in = '0;
      assign val_in  = in_val;
      assign sums_in = in_sums;
    end else begin : g_next
      assign vin     = vld[k-1];
      assign root_in = root_q[k-1];
      assign val_in  = val_q[k-1];
      assign sums_in = sums_q[k-1];
    end

    assign trial    = root_in | (root_t'(1) << (ROOT_W-1-k));
    assign trial_sq = SUM_W'(trial) * SUM_W'(trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en[k]) begin
        vld[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        root_q[k] <= (trial_sq <= val_in) ? trial : root_in;
        val_q[k]  <= val_in;
        sums_q[k] <= sums_in;
      end
    end
  end

endmodule

FILE: hw/rtl/ncc_select.sv
`timescale 1ns / 1ps
module ncc_select #(
  parameter int MAX_CENTERS = ncc_pkg::MAX_CENTERS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [ncc_pkg::ROOT_W-1:0]                  in_root,
  input  logic [MAX_CENTERS-1:0][ncc_pkg::SUM_W-1:0]  in_sums,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [ncc_pkg::IDX_W-1:0]                   index,
  output logic [ncc_pkg::ROOT_W-1:0]                  distance
);
  import ncc_pkg::*;

  localparam int THR_W = SUM_W + 1;

  logic [1:0] vld;
  logic [1:0] en;

  logic [THR_W-1:0]                  thr_q;
  root_t                             root_a_q;
  logic [MAX_CENTERS-1:0][SUM_W-1:0] sums_a_q;
  idx_t                              pick;
  idx_t                              index_q;
  root_t                             dist_q;

  always_comb begin
    en[1] = !vld[1] || out_ready;
    en[0] = !vld[0] || en[1];
  end

  assign in_ready  = en[0];
  assign out_valid = vld[1];
  assign index     = index_q;
  assign distance  = dist_q;

  // Earliest centre whose sum still floors to the minimum root.
  always_comb begin
    pick = '0;
    for (int i = MAX_CENTERS-1; i >= 0; i--) begin
      if (THR_W'(sums_a_q[i]) <= thr_q) pick = IDX_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      thr_q    <= THR_W'(in_root) * (THR_W'(in_root) + THR_W'(2));
      root_a_q <= in_root;
      sums_a_q <= in_sums;
    end
    if (en[1]) begin
      index_q <= pick;
      dist_q  <= root_a_q;
    end
  end

endmodule

FILE: hw/rtl/nearest_color_center_core.sv
// Pipeline: 3 distance, 2 minimum, 9 square root and 2 select stages from input
//   item to result item; the 16-stage pipeline holds one item per stage.
// Throughput: one item per cycle while m_axis_tready keeps the output moving.
// Reset: synchronous active-high rst empties the pipeline, sets center_count
//   to 1 and all centers to 0.
`timescale 1ns / 1ps
`include "nearest_color_center_core_assert.svh"
module nearest_color_center_core #(
  parameter int MAX_CENTERS = ncc_pkg::MAX_CENTERS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // pixel_chan0 [7:0], pixel_chan1 [15:8], pixel_chan2 [23:16]
  input  logic [23:0]                        s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // cluster_index [2:0], nearest_distance [11:3], zero [15:12]
  output logic [15:0]                        m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ncc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ncc_pkg::CENTER_W-1:0]       cfg_data
);
  import ncc_pkg::*;

  logic [CNT_W-1:0]                     center_count;
  logic [MAX_CENTERS-1:0][CENTER_W-1:0] centers;
  logic [CNT_W-1:0]                     count_eff;
  logic [2:0][CHAN_W-1:0]               pixel;

  logic                              d_valid, d_ready;
  logic [MAX_CENTERS-1:0][SUM_W-1:0] d_sums;
  logic                              m_valid, m_ready;
  sum_t                              m_min;
  logic [MAX_CENTERS-1:0][SUM_W-1:0] m_sums;
  logic                              r_valid, r_ready;
  root_t                             r_root;
  logic [MAX_CENTERS-1:0][SUM_W-1:0] r_sums;
  idx_t                              out_index;
  root_t                             out_dist;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_count <= CNT_W'(1);
      centers      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_CENTER_COUNT) center_count <= cfg_data[CNT_W-1:0];
      for (int i = 0; i < MAX_CENTERS; i++) begin
        if (cfg_index == REG_CENTER_BASE + CFG_INDEX_W'(i)) centers[i] <= cfg_data;
      end
    end
  end

  always_comb begin
    if (center_count == '0) begin
      count_eff = CNT_W'(1);
    end else if (center_count > CNT_W'(MAX_CENTERS)) begin
      count_eff = CNT_W'(MAX_CENTERS);
    end else begin
      count_eff = center_count;
    end
  end

  assign pixel[0] = s_axis_tdata[7:0];
  assign pixel[1] = s_axis_tdata[15:8];
  assign pixel[2] = s_axis_tdata[23:16];

  ncc_dist #(.MAX_CENTERS(MAX_CENTERS)) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .pixel     (pixel),
    .centers   (centers),
    .count_eff (count_eff),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .sums      (d_sums)
  );

  ncc_min #(.MAX_CENTERS(MAX_CENTERS)) u_min (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_sums   (d_sums),
    .out_valid (m_valid),
    .out_ready (m_ready),
    .min_sum   (m_min),
    .out_sums  (m_sums)
  );

  ncc_sqrt #(.MAX_CENTERS(MAX_CENTERS)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m_valid),
    .in_ready  (m_ready),
    .in_val    (m_min),
    .in_sums   (m_sums),
    .out_valid (r_valid),
    .out_ready (r_ready),
    .root      (r_root),
    .out_sums  (r_sums)
  );

  ncc_select #(.MAX_CENTERS(MAX_CENTERS)) u_select (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (r_valid),
    .in_ready  (r_ready),
    .in_root   (r_root),
    .in_sums   (r_sums),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .index     (out_index),
    .distance  (out_dist)
  );

  assign m_axis_tdata = {4'b0000, out_dist, out_index};

  `NCC_ASSERT_NOW(a_index_active, m_axis_tvalid, out_index < count_eff, "index beyond active centers")
  `NCC_ASSERT_NOW(a_dist_bound, m_axis_tvalid, out_dist <= 9'd441, "distance out of range")
  `NCC_ASSERT_NOW(a_ready_chain, m_axis_tready, s_axis_tready, "pipeline stalls while sink ready")
  `NCC_ASSERT_NEXT(a_count_write, cfg_valid && cfg_ready && cfg_index == REG_CENTER_COUNT, center_count == $past(cfg_data[CNT_W-1:0]), "count write lost")

endmodule

FILE: sim/nearest_color_center_core_test.sv
`timescale 1ns / 1ps
module nearest_color_center_core_test;
  import ncc_pkg::*;

  localparam int MAX_CENTERS = MAX_CENTERS_DEF;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    root_t distance;
    idx_t  index;
  } label_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [23:0]            s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [15:0]            m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CENTER_W-1:0]    cfg_data = '0;

  logic [CNT_W-1:0]    count_reg;
  logic [CENTER_W-1:0] center_reg [MAX_CENTERS];
  logic [23:0]         pixel_q [$];
  label_t              label_q [$];
  int                  items_queued = 0;
  int                  results_seen = 0;
  int                  mismatches = 0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  logic                pixel_taken = 1'b0;
  logic                hold_req = 1'b0;
  logic                hold_seen = 1'b0;
  int                  hold_left = 0;

  nearest_color_center_core #(
    .MAX_CENTERS(MAX_CENTERS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic root_t floor_root(sum_t s);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = 512;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (mid * mid <= int'(s)) lo = mid;
      else hi = mid;
    end
    return root_t'(lo);
  endfunction

  function automatic label_t classify_pixel(logic [23:0] px);
    label_t best;
    int     n;
    int     diff;
    sum_t   sum;
    root_t  d;
    n = (count_reg == 0) ? 1 : int'(count_reg);
    if (n > MAX_CENTERS) n = MAX_CENTERS;
    best = '0;
    for (int i = 0; i < n; i++) begin
      sum = '0;
      for (int c = 0; c < 3; c++) begin
        diff = int'(px[8*c +: 8]) - int'(center_reg[i][8*c +: 8]);
        sum += sum_t'(diff * diff);
      end
      d = floor_root(sum);
      if (i == 0 || d < best.distance) begin
        best.distance = d;
        best.index = idx_t'(i);
      end
    end
    return best;
  endfunction

  function automatic logic [23:0] random_pixel();
    logic [23:0] px;
    int          n;
    int          base;
    int          v;
    n = (count_reg == 0) ? 1 : int'(count_reg);
    px = 24'($urandom());
    if ($urandom_range(1) == 0) begin
      base = $urandom_range(n - 1);
      for (int c = 0; c < 3; c++) begin
        v = int'(center_reg[base][8*c +: 8]) + int'($urandom_range(16)) - 8;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        px[8*c +: 8] = v[7:0];
      end
    end else if ($urandom_range(7) == 0) begin
      px[8*$urandom_range(2) +: 8] = ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
    end
    return px;
  endfunction

  task automatic push_pixel(logic [23:0] px);
    pixel_q = {pixel_q, px};
    items_queued++;
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CENTER_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == REG_CENTER_COUNT) count_reg = value[CNT_W-1:0];
    else center_reg[idx - REG_CENTER_BASE] = value;
  endtask

  task automatic release_cfg();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (results_seen < items_queued) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_phase(int n_items, logic [CNT_W-1:0] count);
    logic [CENTER_W-1:0] c;
    int                  pick;
    for (int i = 0; i < MAX_CENTERS; i++) begin
      pick = $urandom_range(9);
      if (pick == 0) c = '0;
      else if (pick == 1) c = '1;
      else if (pick <= 3 && i > 0) c = center_reg[$urandom_range(i - 1)];
      else c = CENTER_W'($urandom());
      write_reg(CFG_INDEX_W'(REG_CENTER_BASE + i), c);
    end
    write_reg(REG_CENTER_COUNT, {21'($urandom()), count});
    release_cfg();
    for (int i = 0; i < n_items; i++) push_pixel(random_pixel());
    drain();
  endtask

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || pixel_taken) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata <= pixel_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // long hold-off on request, otherwise random stalls
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check
    label_t want;
    if (rst) begin
      pixel_taken <= 1'b0;
    end else begin
      pixel_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        label_q = {label_q, classify_pixel(s_axis_tdata)};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (label_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected item, expected none, actual %h", $time, m_axis_tdata);
        end else begin
          want = label_q.pop_front();
          if (m_axis_tdata[2:0] !== want.index) begin
            mismatches++;
            $display("%0t: cluster_index expected %0d actual %0d",
                     $time, want.index, m_axis_tdata[2:0]);
          end
          if (m_axis_tdata[11:3] !== want.distance) begin
            mismatches++;
            $display("%0t: nearest_distance expected %0d actual %0d",
                     $time, want.distance, m_axis_tdata[11:3]);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int                  send_modes [4];
    int                  recv_modes [4];
    logic [CNT_W-1:0]    counts [8];
    logic [CENTER_W-1:0] corners [MAX_CENTERS];
    send_modes = '{0, 74, 0, 24};
    recv_modes = '{0, 0, 74, 24};
    counts = '{3'd7, 3'd1, 3'd0, 3'd3, 3'd7, 3'd5, 3'd2, 3'd6};
    corners = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00,
                24'hFF0000, 24'h808080, 24'h000000};
    count_reg = 3'd1;
    for (int i = 0; i < MAX_CENTERS; i++) center_reg[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_pixel(24'h000000);
    push_pixel(24'hFFFFFF);
    push_pixel(24'h010101);
    push_pixel(24'h563412);
    drain();

    write_reg(REG_CENTER_COUNT, 24'h000007);
    for (int i = 0; i < MAX_CENTERS; i++)
      write_reg(CFG_INDEX_W'(REG_CENTER_BASE + i), corners[i]);
    release_cfg();
    push_pixel(24'h000000);
    push_pixel(24'hFFFFFF);
    push_pixel(24'h0000FF);
    push_pixel(24'h00FF00);
    push_pixel(24'hFF0000);
    push_pixel(24'h808080);
    push_pixel(24'h7F7F7F);
    push_pixel(24'h000001);
    push_pixel(24'h404040);
    drain();

    // zero count acts as one; upper data bits ignored
    write_reg(REG_CENTER_COUNT, 24'hFFFFF8);
    release_cfg();
    push_pixel(24'hFFFFFF);
    push_pixel(24'h808080);
    drain();

    write_reg(REG_CENTER_COUNT, 24'hABCDE5);
    release_cfg();
    push_pixel(24'hFE0101);
    push_pixel(24'h7F8081);
    push_pixel(24'h00FFFF);
    drain();

    for (int m = 0; m < 4; m++) begin
      send_idle_pct <= send_modes[m];
      recv_idle_pct <= recv_modes[m];
      random_phase(200, counts[2*m]);
      random_phase(200, counts[2*m + 1]);
    end

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    hold_req <= ~hold_req;
    random_phase(80, 3'd7);

    repeat (40) @(posedge clk);
    if (mismatches == 0 && label_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/ncc_pkg.sv
hw/rtl/ncc_dist.sv
hw/rtl/ncc_min.sv
hw/rtl/ncc_sqrt.sv
hw/rtl/ncc_select.sv
hw/rtl/nearest_color_center_core.sv
sim/nearest_color_center_core_test.sv
